// ===== rtl/lccm_pkg.sv =====
// ----------------------------------------------------------------------------
// lccm_pkg
// Types and constants shared by the looped clip crossfade mixer.
// ----------------------------------------------------------------------------
package lccm_pkg;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned CLIP_WORDS  = 16384;
  localparam int unsigned CLIP_ADDR_W = $clog2(CLIP_WORDS);
  localparam int unsigned POS_W       = 14;
  localparam int unsigned RATIO_W     = 16;
  localparam int unsigned CHAN_CFG_W  = 4;
  localparam int unsigned LOOP_W      = 15;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PROD_W      = SAMPLE_W + RATIO_W + 1;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 16'h8000;
  localparam logic [LOOP_W-1:0]  POS_LIMIT = 15'd16384;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIX_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_FRAMES = 2'd2;

  typedef enum logic [1:0] {
    CMD_MIX  = 2'd0,
    CMD_LOAD = 2'd1,
    CMD_SEEK = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [POS_W-1:0]            target;
    logic                        end_of_block;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  mixed_sample;
    logic                        block_end;
  } out_word_t;

  typedef struct packed {
    logic                        wr_en;
    logic                        rd_en;
    logic [CLIP_ADDR_W-1:0]      addr;
    logic [SAMPLE_W-1:0]         wdata;
  } mem_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        eob;
    logic                        bypass;
    logic [RATIO_W-1:0]          ratio;
    logic [RATIO_W-1:0]          ratio_inv;
  } mix_item_t;

endpackage

// ===== rtl/lccm_clip_store.sv =====
// ----------------------------------------------------------------------------
// lccm_clip_store
// Single-port clip memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module lccm_clip_store (
  input  logic                             clk_i,
  input  lccm_pkg::mem_req_t               req_i,
  output logic [lccm_pkg::SAMPLE_W-1:0]    rdata_o
);
  import lccm_pkg::*;

  logic [SAMPLE_W-1:0] mem [CLIP_WORDS];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  // read data holds while no mix word is taken
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lccm_play_ctrl.sv =====
// ----------------------------------------------------------------------------
// lccm_play_ctrl
// Play position and channel counter, clip address and command decode.
// ----------------------------------------------------------------------------
module lccm_play_ctrl #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  lccm_pkg::in_word_t                 in_word_i,
  input  logic [lccm_pkg::RATIO_W-1:0]       mix_ratio_i,
  input  logic [lccm_pkg::CHAN_CFG_W-1:0]    channels_i,
  input  logic [lccm_pkg::LOOP_W-1:0]        loop_frames_i,
  output lccm_pkg::mem_req_t                 mem_req_o,
  output logic                               item_valid_o,
  output lccm_pkg::mix_item_t                item_o
);
  import lccm_pkg::*;

  localparam int unsigned ChanW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ChW   = CHAN_CFG_W + 1;
  localparam logic [ChW-1:0] MaxCh = ChW'(MAX_CHANNELS);
  localparam int unsigned AddrSumW = POS_W + ChW + 1;

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ChanW-1:0]    chan_q, chan_d;
  logic [ChW-1:0]      ch_raw, ch_eff, chan_inc;
  logic [LOOP_W-1:0]   frames_eff, pos_inc;
  logic [RATIO_W-1:0]  ratio_eff;
  logic [AddrSumW-1:0] addr_sum;
  logic                bypass;
  logic                is_mix;

  always_comb begin
    ch_raw     = (channels_i == '0) ? ChW'(1) : ChW'(channels_i);
    ch_eff     = (ch_raw > MaxCh) ? MaxCh : ch_raw;
    frames_eff = (loop_frames_i > POS_LIMIT) ? POS_LIMIT : loop_frames_i;
    ratio_eff  = (mix_ratio_i > RATIO_ONE) ? RATIO_ONE : mix_ratio_i;
    bypass     = (frames_eff == '0) || (ratio_eff == '0);
    addr_sum   = AddrSumW'(pos_q) * AddrSumW'(ch_eff) + AddrSumW'(chan_q);
    chan_inc   = ChW'(chan_q) + ChW'(1);
    pos_inc    = LOOP_W'(pos_q) + LOOP_W'(1);
    is_mix     = accept_i && (in_word_i.cmd == CMD_MIX);
  end

  always_comb begin
    mem_req_o.wr_en = accept_i && (in_word_i.cmd == CMD_LOAD);
    mem_req_o.rd_en = is_mix;
    mem_req_o.addr  = (in_word_i.cmd == CMD_LOAD) ? CLIP_ADDR_W'(in_word_i.target)
                                                   : addr_sum[CLIP_ADDR_W-1:0];
    mem_req_o.wdata = in_word_i.sample;
  end

  always_comb begin
    item_valid_o     = is_mix;
    item_o.sample    = in_word_i.sample;
    item_o.eob       = in_word_i.end_of_block;
    item_o.bypass    = bypass;
    item_o.ratio     = ratio_eff;
    item_o.ratio_inv = RATIO_ONE - ratio_eff;
  end

  always_comb begin
    pos_d  = pos_q;
    chan_d = chan_q;
    if (accept_i) begin
      unique case (in_word_i.cmd)
        CMD_SEEK: begin
          pos_d  = in_word_i.target;
          chan_d = '0;
        end
        CMD_MIX: begin
          if (!bypass) begin
            if (chan_inc >= ch_eff) begin
              chan_d = '0;
              pos_d  = (pos_inc >= frames_eff) ? '0 : pos_inc[POS_W-1:0];
            end else begin
              chan_d = chan_inc[ChanW-1:0];
            end
          end
        end
        default: begin
          pos_d  = pos_q;
          chan_d = chan_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      chan_q <= '0;
    end else begin
      pos_q  <= pos_d;
      chan_q <= chan_d;
    end
  end

endmodule

// ===== rtl/lccm_mix_pipe.sv =====
// ----------------------------------------------------------------------------
// lccm_mix_pipe
// Crossfade datapath: clip read stage, product stage, output register.
// ----------------------------------------------------------------------------
module lccm_mix_pipe (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  input  lccm_pkg::mix_item_t              item_i,
  input  logic [lccm_pkg::SAMPLE_W-1:0]    clip_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lccm_pkg::out_word_t              out_word_o
);
  import lccm_pkg::*;

  // stage 1: word waits for the clip read
  logic                       v1_q;
  mix_item_t                  s1_q;
  // stage 2: products
  logic                       v2_q;
  logic signed [PROD_W-1:0]   prod_a_q, prod_b_q, prod_a_d, prod_b_d;
  logic signed [SAMPLE_W-1:0] s2_sample_q;
  logic                       s2_eob_q, s2_bypass_q;
  // stage 3: output register
  logic                       v3_q;
  out_word_t                  out_q, out_d;

  logic                       rdy1, rdy2, rdy3;
  logic signed [PROD_W:0]     sum;

  assign rdy3    = !v3_q || out_ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    prod_a_d = PROD_W'(s1_q.sample) * PROD_W'($signed({1'b0, s1_q.ratio_inv}));
    prod_b_d = PROD_W'($signed(clip_i)) * PROD_W'($signed({1'b0, s1_q.ratio}));
  end

  always_comb begin
    // floor shift by 15: take the bits above the fraction
    sum                = {prod_a_q[PROD_W-1], prod_a_q} + {prod_b_q[PROD_W-1], prod_b_q};
    out_d.block_end    = s2_eob_q;
    out_d.mixed_sample = s2_bypass_q ? s2_sample_q : sum[SAMPLE_W+14:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= item_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q <= item_i;
    end
    if (rdy2) begin
      prod_a_q    <= prod_a_d;
      prod_b_q    <= prod_b_d;
      s2_sample_q <= s1_q.sample;
      s2_eob_q    <= s1_q.eob;
      s2_bypass_q <= s1_q.bypass;
    end
    if (rdy3) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/looped_clip_crossfade_mixer_top.sv =====
// ----------------------------------------------------------------------------
// looped_clip_crossfade_mixer_top
// Crossfades a stream of interleaved samples with a looped clip in RAM.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while the output side keeps up; a mix
// word passes the clip RAM read (at the edge that takes it), the product stage
// and the output register before it is offered at the output. The single-port
// clip RAM takes exactly one access per word, load or mix, which sets the rate
// at one word per cycle while the output side keeps up.
// Load and seek words give no output. The clip RAM is not cleared after reset:
// load every entry that will be played before mixing against it.
module looped_clip_crossfade_mixer_top #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lccm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lccm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lccm_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lccm_pkg::out_word_t               out_word_o
);
  import lccm_pkg::*;

  logic [RATIO_W-1:0]    mix_ratio_q;
  logic [CHAN_CFG_W-1:0] channels_q;
  logic [LOOP_W-1:0]     loop_frames_q;

  logic                  accept;
  logic                  pipe_ready;
  mem_req_t              mem_req;
  logic [SAMPLE_W-1:0]   clip_rdata;
  logic                  item_valid;
  mix_item_t             item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_ratio_q   <= '0;
      channels_q    <= CHAN_CFG_W'(2);
      loop_frames_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIX_RATIO:   mix_ratio_q   <= cfg_wdata_i;
        REG_CHANNELS:    channels_q    <= cfg_wdata_i[CHAN_CFG_W-1:0];
        REG_LOOP_FRAMES: loop_frames_q <= cfg_wdata_i[LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = pipe_ready;
  assign accept     = in_valid_i && pipe_ready;

  lccm_play_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_play_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_word_i     (in_word_i),
    .mix_ratio_i   (mix_ratio_q),
    .channels_i    (channels_q),
    .loop_frames_i (loop_frames_q),
    .mem_req_o     (mem_req),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  lccm_clip_store u_clip_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (clip_rdata)
  );

  lccm_mix_pipe u_mix_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .clip_i       (clip_rdata),
    .ready_o      (pipe_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

// ===== verif/lccm_mix_checker.sv =====
// ----------------------------------------------------------------------------
// lccm_mix_checker
// Scoreboard for the looped clip crossfade mixer. It follows the config port
// and both streams, keeps its own copy of the clip store and play cursor, and
// checks each output word against the oldest predicted mix.
// ----------------------------------------------------------------------------
module lccm_mix_checker #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lccm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lccm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  lccm_pkg::in_word_t              in_word_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  lccm_pkg::out_word_t             out_word_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import lccm_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  logic signed [SAMPLE_W-1:0] clip_words [CLIP_WORDS];
  logic [RATIO_W-1:0]         ratio_q;
  logic [CHAN_CFG_W-1:0]      chan_q;
  logic [LOOP_W-1:0]          loop_q;
  int unsigned                play_pos;
  int unsigned                chan_idx;
  out_word_t                  mix_expected_q [$];
  int unsigned                fail_cnt = 0;
  int unsigned                pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  function automatic logic signed [SAMPLE_W-1:0] crossfade(
    input logic signed [SAMPLE_W-1:0] dry,
    input logic signed [SAMPLE_W-1:0] wet,
    input int unsigned                r
  );
    longint acc;
    acc = longint'(dry) * (longint'(RATIO_ONE) - longint'(r)) + longint'(wet) * longint'(r);
    // arithmetic shift rounds towards minus infinity
    return SAMPLE_W'(acc >>> 15);
  endfunction

  task automatic predict_word(input in_word_t w);
    int unsigned r;
    int unsigned frames;
    int unsigned ch;
    int unsigned addr;
    out_word_t   res;
    r      = (ratio_q > RATIO_ONE) ? RATIO_ONE : ratio_q;
    frames = (loop_q > POS_LIMIT) ? POS_LIMIT : loop_q;
    ch     = (chan_q == 0) ? 1 : ((chan_q > MAX_CHANNELS) ? MAX_CHANNELS : chan_q);
    case (w.cmd)
      CMD_LOAD: clip_words[w.target] = w.sample;
      CMD_SEEK: begin
        play_pos = w.target;
        chan_idx = 0;
      end
      CMD_MIX: begin
        res.block_end = w.end_of_block;
        if (frames == 0 || r == 0) begin
          res.mixed_sample = w.sample;
        end else begin
          addr = (play_pos * ch + chan_idx) % CLIP_WORDS;
          res.mixed_sample = crossfade(w.sample, clip_words[addr], r);
          // a stale position or channel is read as is and wraps on this advance
          if (chan_idx + 1 >= ch) begin
            chan_idx = 0;
            play_pos = (play_pos + 1 >= frames) ? 0 : ((play_pos + 1) & ((1 << POS_W) - 1));
          end else begin
            chan_idx = chan_idx + 1;
          end
        end
        mix_expected_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      ratio_q  = '0;
      chan_q   = CHAN_CFG_W'(2);
      loop_q   = '0;
      play_pos = 0;
      chan_idx = 0;
      mix_expected_q.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIX_RATIO:   ratio_q = cfg_wdata_i[RATIO_W-1:0];
          REG_CHANNELS:    chan_q  = cfg_wdata_i[CHAN_CFG_W-1:0];
          REG_LOOP_FRAMES: loop_q  = cfg_wdata_i[LOOP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (mix_expected_q.size() == 0) begin
          if (fail_cnt < REPORT_LIMIT)
            $display("%0t: output word with none predicted: mixed_sample %0d block_end %0b",
                     $realtime, out_word_i.mixed_sample, out_word_i.block_end);
          fail_cnt++;
        end else begin
          want = mix_expected_q.pop_front();
          if (out_word_i.mixed_sample !== want.mixed_sample ||
              out_word_i.block_end !== want.block_end) begin
            if (fail_cnt < REPORT_LIMIT)
              $display("%0t: mixed_sample exp %0d got %0d, block_end exp %0b got %0b",
                       $realtime, want.mixed_sample, out_word_i.mixed_sample,
                       want.block_end, out_word_i.block_end);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        predict_word(in_word_i);
      pending_cnt = mix_expected_q.size();
    end
  end

endmodule

// ===== verif/looped_clip_crossfade_mixer_top_tb.sv =====
// ----------------------------------------------------------------------------
// looped_clip_crossfade_mixer_top_tb
// Stimulus for the looped clip crossfade mixer: directed words at the field
// extremes and corner cases, then random seek/mix sequences over a range of
// ratio, channel and loop settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module looped_clip_crossfade_mixer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lccm_pkg::*;

  localparam int unsigned MAX_CH       = 8;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS  = 28;
  localparam int unsigned IDLE_PCT     = 14;
  localparam int unsigned TIMEOUT_NS   = 1_000_000;

  localparam cmd_e CMD_UNUSED = cmd_e'(2'd3);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_word_o;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus-side view of config and play cursor, used to load clip entries
  // before they are read
  logic [RATIO_W-1:0]    sh_ratio = '0;
  logic [CHAN_CFG_W-1:0] sh_chan  = CHAN_CFG_W'(2);
  logic [LOOP_W-1:0]     sh_loop  = '0;
  int unsigned           cur_pos  = 0;
  int unsigned           cur_chan = 0;
  bit                    loaded [CLIP_WORDS];
  int unsigned           words_sent = 0;
  bit                    idle_on = 1'b1;
  int unsigned           hold_req = 0;

  always #1 clk_i = ~clk_i;

  looped_clip_crossfade_mixer_top #(
    .MAX_CHANNELS(MAX_CH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  lccm_mix_checker #(
    .MAX_CHANNELS(MAX_CH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_i  (out_word_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic int unsigned chan_eff();
    return (sh_chan == 0) ? 1 : ((sh_chan > MAX_CH) ? MAX_CH : sh_chan);
  endfunction

  function automatic int unsigned frames_eff();
    return (sh_loop > POS_LIMIT) ? POS_LIMIT : sh_loop;
  endfunction

  function automatic bit mix_active();
    return frames_eff() != 0 && sh_ratio != 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.cmd != CMD_UNUSED)
      words_sent++;
  endtask

  task automatic send_load(input int unsigned addr, input logic signed [SAMPLE_W-1:0] data);
    in_word_t w;
    w.cmd          = CMD_LOAD;
    w.sample       = data;
    w.target       = POS_W'(addr);
    w.end_of_block = 1'($urandom_range(1));
    send_word(w);
    loaded[addr % CLIP_WORDS] = 1'b1;
  endtask

  task automatic send_seek(input int unsigned target);
    in_word_t w;
    w.cmd          = CMD_SEEK;
    w.sample       = SAMPLE_W'($urandom);
    w.target       = POS_W'(target);
    w.end_of_block = 1'($urandom_range(1));
    send_word(w);
    cur_pos  = target % CLIP_WORDS;
    cur_chan = 0;
  endtask

  task automatic send_unused();
    in_word_t w;
    w.cmd          = CMD_UNUSED;
    w.sample       = SAMPLE_W'($urandom);
    w.target       = POS_W'($urandom);
    w.end_of_block = 1'($urandom_range(1));
    send_word(w);
  endtask

  task automatic send_mix(input logic signed [SAMPLE_W-1:0] data, input bit eob);
    in_word_t    w;
    int unsigned ch;
    int unsigned addr;
    ch = chan_eff();
    // load the entry this mix will read if it has never been written
    if (mix_active()) begin
      addr = (cur_pos * ch + cur_chan) % CLIP_WORDS;
      if (!loaded[addr])
        send_load(addr, rand_sample());
    end
    w.cmd          = CMD_MIX;
    w.sample       = data;
    w.target       = POS_W'($urandom);
    w.end_of_block = eob;
    send_word(w);
    if (mix_active()) begin
      if (cur_chan + 1 >= ch) begin
        cur_chan = 0;
        cur_pos  = (cur_pos + 1 >= frames_eff()) ? 0 : cur_pos + 1;
      end else begin
        cur_chan++;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    // let load and seek words still in flight settle
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(
    input logic [RATIO_W-1:0]    ratio,
    input logic [CHAN_CFG_W-1:0] chan,
    input logic [LOOP_W-1:0]     loop
  );
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MIX_RATIO;
    cfg_wdata_i <= CFG_DATA_W'(ratio);
    @(posedge clk_i);
    cfg_idx_i   <= REG_CHANNELS;
    cfg_wdata_i <= CFG_DATA_W'(chan);
    @(posedge clk_i);
    cfg_idx_i   <= REG_LOOP_FRAMES;
    cfg_wdata_i <= CFG_DATA_W'(loop);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sh_ratio = ratio;
    sh_chan  = chan;
    sh_loop  = loop;
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned stop;
    int unsigned kind;
    int unsigned frames;
    int unsigned ch;
    stop = words_sent + n;
    while (words_sent < stop) begin
      kind   = $urandom_range(99);
      frames = frames_eff();
      ch     = chan_eff();
      if (kind < 70) begin
        // seek then a run of mixes, mostly inside the loop
        if (frames != 0 && $urandom_range(4) != 0)
          send_seek($urandom_range(frames - 1));
        else
          send_seek($urandom_range(POS_LIMIT - 1));
        repeat ($urandom_range(3 * ch, 1)) begin
          if ($urandom_range(9) == 0) begin
            if ($urandom_range(1))
              send_unused();
            else
              send_load($urandom_range(CLIP_WORDS - 1), rand_sample());
          end
          send_mix(rand_sample(), $urandom_range(7) == 0);
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(ch, 1))
          send_mix(rand_sample(), $urandom_range(7) == 0);
      end else if (kind < 93) begin
        send_load($urandom_range(CLIP_WORDS - 1), rand_sample());
      end else if (kind < 97) begin
        send_unused();
      end else begin
        send_seek($urandom_range(POS_LIMIT - 1));
      end
    end
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned          k;
    logic [RATIO_W-1:0]   ratio;
    logic [LOOP_W-1:0]    loop;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings bypass: extremes pass straight through
    send_mix(SAMPLE_MAX, 1'b1);
    send_mix(SAMPLE_MIN, 1'b0);
    send_mix('0, 1'b1);
    send_mix('1, 1'b0);
    send_unused();
    send_seek(POS_LIMIT - 1);
    send_mix(rand_sample(), 1'b1);

    // full clip weight, wrap at the loop end, stale position after a far seek
    set_config(RATIO_ONE, CHAN_CFG_W'(1), LOOP_W'(4));
    send_load(0, SAMPLE_MAX);
    send_load(1, SAMPLE_MIN);
    send_seek(0);
    repeat (5) send_mix(rand_sample(), 1'b0);
    send_seek(10);
    repeat (2) send_mix(SAMPLE_MIN, 1'b1);
    send_load(CLIP_WORDS - 1, SAMPLE_MIN);

    // leave the channel index mid-frame, then shrink the frame under it
    set_config(RATIO_W'(16384), CHAN_CFG_W'(8), LOOP_W'(2));
    send_seek(0);
    repeat (5) send_mix(rand_sample(), 1'b0);
    set_config(RATIO_W'(16384), CHAN_CFG_W'(2), LOOP_W'(2));
    repeat (2) send_mix(SAMPLE_MAX, 1'b0);

    set_config(RATIO_W'(16'hFFFF), CHAN_CFG_W'(8), LOOP_W'(3));
    run_phase(PHASE_WORDS);
    // hold the output off while words keep arriving
    hold_req++;
    repeat (60) send_mix(rand_sample(), $urandom_range(7) == 0);

    set_config(RATIO_W'(1), CHAN_CFG_W'(0), POS_LIMIT);
    run_phase(PHASE_WORDS / 2);
    wait_drained();
    run_phase(PHASE_WORDS / 2);

    set_config(RATIO_W'(16384), CHAN_CFG_W'(15), LOOP_W'(15'h7FFF));
    run_phase(PHASE_WORDS);

    idle_on = 1'b0;
    set_config(RATIO_W'(0), CHAN_CFG_W'(3), LOOP_W'(5));
    run_phase(PHASE_WORDS);
    set_config(RATIO_W'(32767), CHAN_CFG_W'(2), LOOP_W'(0));
    run_phase(PHASE_WORDS);
    set_config(RATIO_ONE, CHAN_CFG_W'(8), POS_LIMIT);
    run_phase(PHASE_WORDS);
    idle_on = 1'b1;

    for (k = 0; k < 9; k++) begin
      case ($urandom_range(5))
        0:       ratio = '0;
        1:       ratio = RATIO_ONE;
        2:       ratio = RATIO_W'($urandom);
        default: ratio = RATIO_W'($urandom_range(32768, 1));
      endcase
      case ($urandom_range(7))
        0:       loop = '0;
        1:       loop = POS_LIMIT;
        2:       loop = LOOP_W'($urandom);
        default: loop = LOOP_W'($urandom_range(12, 1));
      endcase
      set_config(ratio, CHAN_CFG_W'($urandom_range(15)), loop);
      run_phase(PHASE_WORDS);
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lccm_pkg.sv
rtl/lccm_clip_store.sv
rtl/lccm_play_ctrl.sv
rtl/lccm_mix_pipe.sv
rtl/looped_clip_crossfade_mixer_top.sv
verif/lccm_mix_checker.sv
verif/looped_clip_crossfade_mixer_top_tb.sv
